[hw/rtl/b64u_pkg.sv]
// Shared types, status codes and character decode for the base64url decoder.
package b64u_pkg;

	localparam int MaxDecodedDef = 2048;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_LENGTH = 3'd1,
		ST_PADDING    = 3'd2,
		ST_INVALID    = 3'd3,
		ST_TOO_LONG   = 3'd4,
		ST_LEFTOVER   = 3'd5
	} status_t;

	// pending bit count 0, 6, 4, 2
	typedef enum logic [3:0] {
		PH_0 = 4'b0001,
		PH_6 = 4'b0010,
		PH_4 = 4'b0100,
		PH_2 = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       done_res;
		status_t    status;
	} res_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} sextet_t;

	localparam logic [7:0] ChPad   = 8'h3D;
	localparam logic [7:0] ChDash  = 8'h2D;
	localparam logic [7:0] ChUnder = 8'h5F;

	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t s;
		s.ok  = 1'b1;
		s.val = 6'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			s.val = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			s.val = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			s.val = 6'(c - 8'h30 + 8'd52);
		end else if (c == ChDash) begin
			s.val = 6'd62;
		end else if (c == ChUnder) begin
			s.val = 6'd63;
		end else begin
			s.ok = 1'b0;
		end
		return s;
	endfunction

endpackage

[hw/rtl/base64url_strict_decoder_core.sv]
// Streaming unpadded base64url decoder, one character per cycle when not stalled.
//
// Request channel (req_valid, req_stall, req): one character of the string
// per request, with last set on the final character. Result channel
// (res_valid, res_stall, res): exactly one result per request, in order.
// A result carries a decoded byte when byte_valid is set; the result of the
// last character has done_res set and the status of the whole string.
// Bytes stream out as they complete, so the consumer keeps them only if the
// final status is ok. After the first error no further bytes are flagged.
//
// The request is registered, then decoded against the running state into the
// result register. Throughput is one character per cycle while the result
// channel does not stall; the bit packer updates its state for each character.
// req_stall rises only while the result register holds an untaken result and
// the input register is full; a stalled result holds its value.
// Reset (arst_n low) empties both registers and clears the string state; the
// state is also cleared after each last character.
module base64url_strict_decoder_core
	import b64u_pkg::*;
#(
	parameter int MAX_DECODED = MaxDecodedDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int CW = $clog2(2 * MAX_DECODED + 2);
	localparam int BW = $clog2(MAX_DECODED + 2);
	localparam logic [CW-1:0] CharLimit = CW'(2 * MAX_DECODED);
	localparam logic [BW-1:0] ByteMax   = BW'(MAX_DECODED);

	logic             s1_valid_q;
	req_t             req_s1;
	logic             res_valid_q;
	res_t             res_q;

	phase_t           ph_q, ph_nx;
	logic [5:0]       lb_q, lb_nx;
	logic [CW-1:0]    cc_q, cc_nx;
	logic [BW-1:0]    bc_q, bc_nx;
	status_t          err_q, err_nx;

	logic             res_free;
	logic             adv;
	sextet_t          sx;
	logic             byte_mk;
	logic [7:0]       byte_raw;
	res_t             res_nx;

	assign res_free  = !res_valid_q || !res_stall;
	assign adv       = s1_valid_q && res_free;
	assign req_stall = s1_valid_q && !res_free;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		sx       = sextet_of(req_s1.ch);
		cc_nx    = (cc_q <= CharLimit) ? cc_q + CW'(1) : cc_q;
		err_nx   = err_q;
		ph_nx    = ph_q;
		lb_nx    = lb_q;
		bc_nx    = bc_q;
		byte_mk  = 1'b0;
		byte_raw = 8'd0;
		res_nx   = '{out_byte: 8'd0, byte_valid: 1'b0, done_res: 1'b0, status: ST_OK};

		if (err_q == ST_OK) begin
			if (req_s1.ch == ChPad) begin
				err_nx = ST_PADDING;
			end else if (!sx.ok) begin
				err_nx = ST_INVALID;
			end else begin
				unique case (ph_q)
					PH_0: begin
						ph_nx = PH_6;
						lb_nx = sx.val;
					end
					PH_6: begin
						byte_mk  = 1'b1;
						byte_raw = {lb_q, sx.val[5:4]};
						ph_nx    = PH_4;
						lb_nx    = {2'b00, sx.val[3:0]};
					end
					PH_4: begin
						byte_mk  = 1'b1;
						byte_raw = {lb_q[3:0], sx.val[5:2]};
						ph_nx    = PH_2;
						lb_nx    = {4'b0000, sx.val[1:0]};
					end
					PH_2: begin
						byte_mk  = 1'b1;
						byte_raw = {lb_q[1:0], sx.val};
						ph_nx    = PH_0;
						lb_nx    = 6'd0;
					end
					default: begin
						ph_nx = PH_0;
						lb_nx = 6'd0;
					end
				endcase
				if (byte_mk) begin
					bc_nx = bc_q + BW'(1);
					// the byte that crosses the limit is dropped
					if (bc_q == ByteMax) begin
						err_nx = ST_TOO_LONG;
					end else begin
						res_nx.byte_valid = 1'b1;
						res_nx.out_byte   = byte_raw;
					end
				end
			end
		end

		if (req_s1.last) begin
			res_nx.done_res = 1'b1;
			if (cc_nx > CharLimit) begin
				res_nx.status = ST_TOO_LONG;
			end else if (cc_nx[1:0] == 2'd1) begin
				res_nx.status = ST_BAD_LENGTH;
			end else if (err_nx != ST_OK) begin
				res_nx.status = err_nx;
			end else if (ph_nx != PH_0 && lb_nx != 6'd0) begin
				res_nx.status = ST_LEFTOVER;
			end else begin
				res_nx.status = ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
			ph_q        <= PH_0;
			lb_q        <= 6'd0;
			cc_q        <= '0;
			bc_q        <= '0;
			err_q       <= ST_OK;
		end else begin
			if (!req_stall) begin
				s1_valid_q <= req_valid;
			end
			if (res_free) begin
				res_valid_q <= s1_valid_q;
			end
			if (adv) begin
				if (req_s1.last) begin
					ph_q  <= PH_0;
					lb_q  <= 6'd0;
					cc_q  <= '0;
					bc_q  <= '0;
					err_q <= ST_OK;
				end else begin
					ph_q  <= ph_nx;
					lb_q  <= lb_nx;
					cc_q  <= cc_nx;
					bc_q  <= bc_nx;
					err_q <= err_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (adv) begin
			res_q <= res_nx;
		end
	end

`ifndef SYNTHESIS
	a_status_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.done_res |-> res.status == ST_OK)
		else $error("status set on a result that is not the last");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.byte_valid |-> res.out_byte == 8'd0)
		else $error("out_byte nonzero without byte_valid");

	a_no_byte_after_err: assert property (@(posedge clk) disable iff (!arst_n)
		adv && err_q != ST_OK |=> !res.byte_valid)
		else $error("byte emitted after an error");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && req_s1.last |=> ph_q == PH_0 && cc_q == '0 && bc_q == '0)
		else $error("string state not cleared after last character");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> s1_valid_q && res_valid_q)
		else $error("request stalled with room in the pipeline");
`endif

endmodule

[bench/testbench.sv]
// Self-checking testbench for base64url_strict_decoder_core: random strings, scoreboard, stalls.
`timescale 1ns / 100ps

module testbench;
	import b64u_pkg::*;

	localparam int MaxBytes  = MaxDecodedDef;
	localparam int CharLimit = 2 * MaxBytes;
	localparam int CycleLimit = 4_000_000;
	localparam int RandomRequests = 1450;
	localparam int ReportCap = 200;

	typedef bit [7:0] chars_t[$];

	class b64_scoreboard;
		bit [5:0]   pend_bits;
		bit [2:0]   pend_cnt;
		bit [12:0]  char_cnt;
		bit [11:0]  byte_cnt;
		status_t    first_err;
		res_t       expected_q[$];
		int         errors;
		int         strings_seen;
		int         bytes_seen;
		int         status_seen[6];

		function new();
			clear_string();
		endfunction

		function void clear_string();
			pend_bits = '0;
			pend_cnt  = '0;
			char_cnt  = '0;
			byte_cnt  = '0;
			first_err = ST_OK;
		endfunction

		// alphabet value of a character, -1 when it is not in the alphabet
		function int sextet_value(bit [7:0] c);
			if (c inside {[8'h41:8'h5A]}) return int'(c) - 'h41;
			if (c inside {[8'h61:8'h7A]}) return int'(c) - 'h61 + 26;
			if (c inside {[8'h30:8'h39]}) return int'(c) - 'h30 + 52;
			if (c == ChDash) return 62;
			if (c == ChUnder) return 63;
			return -1;
		endfunction

		function void note_request(req_t r);
			res_t      want;
			int        v;
			bit [11:0] packed_bits;
			int        nbits;
			want = '{out_byte: 8'h00, byte_valid: 1'b0, done_res: 1'b0, status: ST_OK};
			if (char_cnt <= CharLimit)
				char_cnt++;
			if (first_err == ST_OK) begin
				v = sextet_value(r.ch);
				if (r.ch == ChPad) begin
					first_err = ST_PADDING;
				end else if (v < 0) begin
					first_err = ST_INVALID;
				end else begin
					packed_bits = {pend_bits, 6'(v)};
					nbits = int'(pend_cnt) + 6;
					if (nbits >= 8) begin
						nbits -= 8;
						byte_cnt++;
						if (byte_cnt > MaxBytes) begin
							first_err = ST_TOO_LONG;
						end else begin
							want.out_byte = 8'(packed_bits >> nbits);
							want.byte_valid = 1'b1;
						end
					end
					pend_cnt = 3'(nbits);
					pend_bits = 6'(packed_bits & ((12'd1 << nbits) - 12'd1));
				end
			end
			if (r.last) begin
				want.done_res = 1'b1;
				if (char_cnt > CharLimit)
					want.status = ST_TOO_LONG;
				else if (char_cnt[1:0] == 2'd1)
					want.status = ST_BAD_LENGTH;
				else if (first_err != ST_OK)
					want.status = first_err;
				else if (pend_cnt != 0 && pend_bits != 0)
					want.status = ST_LEFTOVER;
				else
					want.status = ST_OK;
				clear_string();
			end
			expected_q.insert(expected_q.size(), want);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= ReportCap)
					$error("result with no request pending: %p", got);
				return;
			end
			want = expected_q.pop_front();
			if (got.out_byte !== want.out_byte) begin
				errors++;
				if (errors <= ReportCap)
					$error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
			end
			if (got.byte_valid !== want.byte_valid) begin
				errors++;
				if (errors <= ReportCap)
					$error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
			end
			if (got.done_res !== want.done_res) begin
				errors++;
				if (errors <= ReportCap)
					$error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
			end
			if (got.status !== want.status) begin
				errors++;
				if (errors <= ReportCap)
					$error("status: expected %0d, got %0d", want.status, got.status);
			end
			if (want.byte_valid)
				bytes_seen++;
			if (want.done_res) begin
				strings_seen++;
				status_seen[int'(want.status)]++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	b64_scoreboard sb = new();
	bit calm = 1'b0;
	int requests_sent = 0;
	int cycles = 0;

	base64url_strict_decoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("[base64url_strict_decoder_core] ERROR");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && res_valid && !res_stall)
			sb.check_result(res);

	// mostly short gaps, now and then a long one; none during calm stretches
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(10, 4);
		return $urandom_range(40, 15);
	endfunction

	function automatic bit [7:0] alpha_char(bit [5:0] v);
		if (v < 26)
			return 8'h41 + 8'(v);
		if (v < 52)
			return 8'h61 + 8'(v - 26);
		if (v < 62)
			return 8'h30 + 8'(v - 52);
		return (v == 6'd62) ? ChDash : ChUnder;
	endfunction

	// random alphabet string; clean_tail zeroes the bits left over by the last char
	function automatic chars_t alpha_string(int len, bit clean_tail);
		chars_t q;
		bit [5:0] v;
		for (int i = 0; i < len; i++) begin
			v = 6'($urandom);
			if (clean_tail && i == len - 1) begin
				if (len % 4 == 2)
					v[3:0] = '0;
				else if (len % 4 == 3)
					v[1:0] = '0;
			end
			q.insert(q.size(), alpha_char(v));
		end
		return q;
	endfunction

	function automatic chars_t from_text(string s);
		chars_t q;
		for (int i = 0; i < s.len(); i++)
			q.insert(q.size(), s[i]);
		return q;
	endfunction

	function automatic bit [7:0] junk_char();
		bit [7:0] c;
		do
			c = 8'($urandom_range(255));
		while (sb.sextet_value(c) >= 0 || c == ChPad);
		return c;
	endfunction

	task automatic send_request(req_t r);
		int g;
		g = pick_gap();
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(r);
		requests_sent++;
	endtask

	task automatic send_string(chars_t q);
		req_t r;
		for (int i = 0; i < q.size(); i++) begin
			r.ch = q[i];
			r.last = (i == q.size() - 1);
			send_request(r);
		end
	endtask

	initial begin
		int wait_cycles;
		forever begin
			wait_cycles = pick_gap();
			if (wait_cycles > 0) begin
				res_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
				res_stall <= 1'b0;
			end
			@(posedge clk);
		end
	end

	initial begin
		chars_t q;
		int start_count;
		int kind;
		int k;
		int len;
		int pos;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: plain decode, alphabet extremes, leftover bits, bad length,
		// padding, bytes outside the alphabet, padding as a lone char
		calm = 1'b1;
		send_string(from_text("TWFu"));
		calm = 1'b0;
		send_string(from_text("_w"));
		send_string(from_text("AB"));
		send_string(from_text("A"));
		send_string(from_text("QQ=="));
		q = '{8'hFF, 8'h00, 8'h39};
		send_string(q);
		send_string(from_text("z9-"));
		send_string(from_text("="));

		start_count = requests_sent;
		while (requests_sent - start_count < RandomRequests) begin
			calm = ($urandom_range(99) < 15);
			kind = $urandom_range(99);
			k = ($urandom_range(9) == 0) ? $urandom_range(30, 11) : $urandom_range(10);
			case ($urandom_range(2))
				0: len = 4 * k;
				1: len = 4 * k + 2;
				default: len = 4 * k + 3;
			endcase
			if (len == 0)
				len = 4;
			if (kind < 65) begin
				q = alpha_string(len, $urandom_range(3) != 0);
			end else if (kind < 75) begin
				q = alpha_string(4 * k + 1, 1'b1);
			end else if (kind < 90) begin
				q = alpha_string(len, 1'b1);
				pos = $urandom_range(len - 1);
				case ($urandom_range(2))
					0: q[pos] = ChPad;
					1: q[pos] = junk_char();
					default: begin
						q.insert(q.size(), ChPad);
						while (q.size() % 4 != 0)
							q.insert(q.size(), ChPad);
					end
				endcase
			end else begin
				q.delete();
				len = $urandom_range(12, 1);
				for (int i = 0; i < len; i++)
					q.insert(q.size(), 8'($urandom_range(255)));
			end
			send_string(q);
		end
		calm = 1'b0;

		req_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("ran %0d requests in %0d strings, %0d bytes decoded", requests_sent,
			sb.strings_seen, sb.bytes_seen);
		$display("status ok %0d, length %0d, pad %0d, invalid %0d, too long %0d, leftover %0d",
			sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
			sb.status_seen[4], sb.status_seen[5]);
		if (sb.errors == 0)
			$display("[base64url_strict_decoder_core] OK");
		else
			$display("[base64url_strict_decoder_core] ERROR");
		$finish;
	end

endmodule

[files.f]
hw/rtl/b64u_pkg.sv
hw/rtl/base64url_strict_decoder_core.sv
bench/testbench.sv
